>>> hw/rtl/dls_pkg.sv
package dls_pkg;

    // default sizes
    localparam int ADDR_DEPTH_DEF = 1024;
    localparam int MAX_INSTR_DEF  = 64;
    localparam int MAX_ARGS_DEF   = 8;
    localparam int OP_BITS_DEF    = 8;

    // fixed field widths
    localparam int ADDR_IN_W = 10;
    localparam int OP_IN_W   = 8;
    localparam int INDEX_W   = 6;
    localparam int LEVEL_W   = 7;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic lookup;
        logic close;
        logic wb_step;
        logic scan_start;
        logic scan_step;
        logic emit_done;
        logic clear_step;
        logic clear_end;
    } dls_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic closes;
        logic prog_end;
        logic wb_needed;
        logic wb_last;
        logic count_zero;
        logic scan_last;
        logic emit_last;
    } dls_status_t;

endpackage

>>> hw/rtl/dls_in_if.sv
interface dls_in_if;
    import dls_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_IN_W-1:0] arg_address;
    logic                 arg_reads;
    logic                 arg_writes;
    logic [OP_IN_W-1:0]   op_kind;
    logic                 last_arg;
    logic                 last_instr;

    modport source (output valid, arg_address, arg_reads, arg_writes, op_kind,
                    last_arg, last_instr, input ready);
    modport sink   (input valid, arg_address, arg_reads, arg_writes, op_kind,
                    last_arg, last_instr, output ready);
endinterface

>>> hw/rtl/dls_out_if.sv
interface dls_out_if;
    import dls_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] instr_index;
    logic [LEVEL_W-1:0] sched_level;
    logic [OP_IN_W-1:0] out_op_kind;
    logic               overflow;
    logic               last;

    modport source (output valid, instr_index, sched_level, out_op_kind, overflow, last,
                    input ready);
    modport sink   (input valid, instr_index, sched_level, out_op_kind, overflow, last,
                    output ready);
endinterface

>>> hw/rtl/dls_ram.sv
module dls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/dls_ctrl.sv
module dls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dls_pkg::dls_status_t st,
    output dls_pkg::dls_cmd_t    cmd
);
    import dls_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOKUP = 9'b000000100,
        S_CLOSE  = 9'b000001000,
        S_WB     = 9'b000010000,
        S_PREP   = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_FLUSH  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    cmd.clear_end = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = st.closes ? S_CLOSE : S_IDLE;
            end
            S_CLOSE:
            begin
                cmd.close = 1'b1;
                if (st.wb_needed)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = st.prog_end ? S_PREP : S_IDLE;
                end
            end
            S_WB:
            begin
                cmd.wb_step = 1'b1;
                if (st.wb_last)
                begin
                    state_next = st.prog_end ? S_PREP : S_IDLE;
                end
            end
            S_PREP:
            begin
                cmd.scan_start = 1'b1;
                state_next     = st.count_zero ? S_CLEAR : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = st.emit_last ? S_CLEAR : S_PREP;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // checks
    a_emit_has_items: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !st.count_zero)
        else $error("emitting with no recorded instruction");
    a_scan_after_prep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_SCAN) |-> $past(state_reg == S_PREP))
        else $error("scan not started by prep");
    a_close_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLOSE) |-> $past(state_reg == S_LOOKUP))
        else $error("close without lookup");
endmodule

>>> hw/rtl/dls_datapath.sv
module dls_datapath #(
    parameter int ADDR_DEPTH = dls_pkg::ADDR_DEPTH_DEF,
    parameter int MAX_INSTR  = dls_pkg::MAX_INSTR_DEF,
    parameter int MAX_ARGS   = dls_pkg::MAX_ARGS_DEF,
    parameter int OP_BITS    = dls_pkg::OP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dls_pkg::dls_cmd_t               cmd,
    output dls_pkg::dls_status_t            st,
    input  logic [dls_pkg::ADDR_IN_W-1:0]   arg_address,
    input  logic                            arg_reads,
    input  logic                            arg_writes,
    input  logic [dls_pkg::OP_IN_W-1:0]     op_kind,
    input  logic                            last_arg,
    input  logic                            last_instr,
    output logic [dls_pkg::INDEX_W-1:0]     instr_index,
    output logic [dls_pkg::LEVEL_W-1:0]     sched_level,
    output logic [dls_pkg::OP_IN_W-1:0]     out_op_kind,
    output logic                            overflow,
    output logic                            last
);
    import dls_pkg::*;

    localparam int AW   = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
    localparam int RIW  = $clog2(MAX_INSTR);
    localparam int ICW  = $clog2(MAX_INSTR + 1);
    localparam int PW   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int PCW  = $clog2(MAX_ARGS + 1);
    localparam int OPW  = (OP_BITS < OP_IN_W) ? OP_BITS : OP_IN_W;
    localparam int RECW = LEVEL_W + OPW;
    localparam int KEYW = RECW + RIW;

    // latched item
    logic [AW-1:0]  addr_reg;
    logic           rd_reg, wr_reg, close_reg, end_reg;
    logic [OPW-1:0] op_reg;

    // instruction and program state
    logic [AW-1:0]      pend_reg [MAX_ARGS];
    logic [PCW-1:0]     pend_cnt_reg;
    logic [LEVEL_W-1:0] max_reg;
    logic [ICW-1:0]     instr_cnt_reg;
    logic               ovf_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [PCW-1:0]     wb_cnt_reg;
    logic [PW-1:0]      wb_idx_reg;
    logic [AW-1:0]      clr_addr_reg;

    // sort scan state
    logic [RIW-1:0]  scan_idx_reg, cmp_idx_reg;
    logic            cmp_valid_reg;
    logic [KEYW-1:0] best_key_reg, prev_key_reg;
    logic            best_found_reg, has_prev_reg;
    logic [ICW-1:0]  emitted_reg;

    logic [LEVEL_W-1:0] tbl_rdata, tbl_wdata, new_lvl;
    logic [AW-1:0]      tbl_waddr;
    logic               tbl_we, has_room;
    logic [RECW-1:0]    rec_rdata;
    logic [KEYW-1:0]    cand_key;

    // address level table
    dls_ram #(.WIDTH(LEVEL_W), .DEPTH(ADDR_DEPTH)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (AW'(arg_address)),
        .rdata (tbl_rdata)
    );

    // instruction records: level and op kind
    dls_ram #(.WIDTH(RECW), .DEPTH(MAX_INSTR)) u_rec (
        .clk   (clk),
        .we    (cmd.close && has_room),
        .waddr (instr_cnt_reg[RIW-1:0]),
        .wdata ({new_lvl, op_reg}),
        .raddr (scan_idx_reg),
        .rdata (rec_rdata)
    );

    assign has_room  = (instr_cnt_reg < ICW'(MAX_INSTR));
    assign new_lvl   = (max_reg == LEVEL_MAX) ? LEVEL_MAX : max_reg + LEVEL_W'(1);
    assign tbl_we    = cmd.clear_step || cmd.wb_step;
    assign tbl_waddr = cmd.clear_step ? clr_addr_reg : pend_reg[wb_idx_reg];
    assign tbl_wdata = cmd.clear_step ? '0 : lvl_reg;
    assign cand_key  = {rec_rdata, cmp_idx_reg};

    // status
    always_comb
    begin
        st            = '0;
        st.clear_last = (clr_addr_reg == AW'(ADDR_DEPTH - 1));
        st.closes     = close_reg;
        st.prog_end   = end_reg;
        st.wb_needed  = has_room && (pend_cnt_reg != '0);
        st.wb_last    = (PCW'(wb_idx_reg) + PCW'(1) == wb_cnt_reg);
        st.count_zero = (instr_cnt_reg == '0);
        st.scan_last  = (ICW'(scan_idx_reg) + ICW'(1) == instr_cnt_reg);
        st.emit_last  = (emitted_reg + ICW'(1) == instr_cnt_reg);
    end

    // item latch and pending write list
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg  <= AW'(arg_address);
            rd_reg    <= arg_reads;
            wr_reg    <= arg_writes;
            op_reg    <= op_kind[OPW-1:0];
            close_reg <= last_arg || last_instr;
            end_reg   <= last_instr;
        end
        if (cmd.lookup && wr_reg && (pend_cnt_reg < PCW'(MAX_ARGS)))
        begin
            pend_reg[pend_cnt_reg[PW-1:0]] <= addr_reg;
        end
        if (cmd.close)
        begin
            lvl_reg    <= new_lvl;
            wb_cnt_reg <= pend_cnt_reg;
        end
    end

    // counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= '0;
            max_reg       <= '0;
            instr_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            wb_idx_reg    <= '0;
            clr_addr_reg  <= '0;
            emitted_reg   <= '0;
            has_prev_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.clear_end)
            begin
                clr_addr_reg  <= '0;
                pend_cnt_reg  <= '0;
                max_reg       <= '0;
                instr_cnt_reg <= '0;
                ovf_reg       <= 1'b0;
                emitted_reg   <= '0;
                has_prev_reg  <= 1'b0;
            end
            if (cmd.lookup)
            begin
                if (rd_reg && (tbl_rdata > max_reg))
                begin
                    max_reg <= tbl_rdata;
                end
                if (wr_reg)
                begin
                    if (pend_cnt_reg < PCW'(MAX_ARGS))
                    begin
                        pend_cnt_reg <= pend_cnt_reg + PCW'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.close)
            begin
                pend_cnt_reg <= '0;
                max_reg      <= '0;
                wb_idx_reg   <= '0;
                if (has_room)
                begin
                    instr_cnt_reg <= instr_cnt_reg + ICW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.wb_step)
            begin
                wb_idx_reg <= wb_idx_reg + PW'(1);
            end
            if (cmd.emit_done)
            begin
                emitted_reg  <= emitted_reg + ICW'(1);
                has_prev_reg <= 1'b1;
            end
        end
    end

    // scan: find smallest key above the one emitted last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + RIW'(1);
            end
            if (cmp_valid_reg && (!has_prev_reg || (cand_key > prev_key_reg))
                && (!best_found_reg || (cand_key < best_key_reg)))
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_valid_reg && (!has_prev_reg || (cand_key > prev_key_reg))
            && (!best_found_reg || (cand_key < best_key_reg)))
        begin
            best_key_reg <= cand_key;
        end
        if (cmd.emit_done)
        begin
            prev_key_reg <= best_key_reg;
        end
    end

    // result fields
    assign instr_index = INDEX_W'(best_key_reg[RIW-1:0]);
    assign out_op_kind = OP_IN_W'(best_key_reg[RIW +: OPW]);
    assign sched_level = best_key_reg[KEYW-1 -: LEVEL_W];
    assign overflow    = ovf_reg;
    assign last        = st.emit_last;

    // checks
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= PCW'(MAX_ARGS))
        else $error("pending write count beyond capacity");
    a_instr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        instr_cnt_reg <= ICW'(MAX_INSTR))
        else $error("instruction count beyond capacity");
    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |-> best_found_reg)
        else $error("transfer without a selected instruction");
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> (pend_cnt_reg == '0) && (max_reg == '0))
        else $error("instruction state not cleared on close");
endmodule

>>> hw/rtl/dependency_level_scheduler_top.sv
// Dependency level scheduler. Takes a program one argument per transfer and,
// after the item marked last_instr, emits every recorded instruction sorted
// by level, then op kind, then program index. Each argument goes through a
// level table read, then a compare; closing an instruction adds a close step
// plus a write-back step per stored written address. Each result of the
// schedule rescans the record memory through its single read port. After
// reset and after each schedule, a clearing pass over every level table
// address zeroes it; no input transfer is taken meanwhile. ADDR_DEPTH must
// be a power of two; the block itself does not enforce it.
module dependency_level_scheduler_top #(
    parameter int ADDR_DEPTH = dls_pkg::ADDR_DEPTH_DEF,
    parameter int MAX_INSTR  = dls_pkg::MAX_INSTR_DEF,
    parameter int MAX_ARGS   = dls_pkg::MAX_ARGS_DEF,
    parameter int OP_BITS    = dls_pkg::OP_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    dls_in_if.sink    in_ch,
    dls_out_if.source out_ch
);
    import dls_pkg::*;

    dls_cmd_t    cmd;
    dls_status_t st;

    // controller
    dls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath
    dls_datapath #(
        .ADDR_DEPTH (ADDR_DEPTH),
        .MAX_INSTR  (MAX_INSTR),
        .MAX_ARGS   (MAX_ARGS),
        .OP_BITS    (OP_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .arg_address (in_ch.arg_address),
        .arg_reads   (in_ch.arg_reads),
        .arg_writes  (in_ch.arg_writes),
        .op_kind     (in_ch.op_kind),
        .last_arg    (in_ch.last_arg),
        .last_instr  (in_ch.last_instr),
        .instr_index (out_ch.instr_index),
        .sched_level (out_ch.sched_level),
        .out_op_kind (out_ch.out_op_kind),
        .overflow    (out_ch.overflow),
        .last        (out_ch.last)
    );
endmodule

>>> test/tb.sv
module tb;
    import dls_pkg::*;

    // one argument transfer on the input channel
    typedef struct packed {
        logic [ADDR_IN_W-1:0] addr;
        logic                 rd;
        logic                 wr;
        logic [OP_IN_W-1:0]   op;
        logic                 la;
        logic                 li;
    } arg_t;

    // one scheduled instruction on the output channel
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [LEVEL_W-1:0] lvl;
        logic [OP_IN_W-1:0] op;
        logic               ovf;
        logic               last;
    } sched_t;

    localparam int TABLE_SIZE = ADDR_DEPTH_DEF;
    localparam int INSTR_CAP  = MAX_INSTR_DEF;
    localparam int WRITE_CAP  = MAX_ARGS_DEF;
    localparam int STALL_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n;

    dls_in_if  in_ch ();
    dls_out_if out_ch ();

    dependency_level_scheduler_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [LEVEL_W-1:0] level_of_addr [TABLE_SIZE];
    logic [LEVEL_W-1:0] instr_level [INSTR_CAP];
    logic [OP_IN_W-1:0] instr_op [INSTR_CAP];
    logic [ADDR_IN_W-1:0] write_addr [WRITE_CAP];
    int unsigned write_cnt;
    int unsigned max_read_level;
    int unsigned instr_cnt;
    logic        dropped;

    sched_t schedule_q [$];
    int errors = 0;
    int items_sent;
    int src_idle;
    int snk_idle;
    int quiet_cycles = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_model();
        for (int i = 0; i < TABLE_SIZE; i++)
            level_of_addr[i] = '0;
        write_cnt = 0;
        max_read_level = 0;
        instr_cnt = 0;
        dropped = 1'b0;
    endtask

    // builds the sorted schedule of the current program
    task automatic queue_schedule();
        logic [20:0] key [INSTR_CAP];
        logic [20:0] k;
        sched_t s;
        int j;
        for (int i = 0; i < instr_cnt; i++)
            key[i] = {instr_level[i], instr_op[i], i[INDEX_W-1:0]};
        for (int i = 1; i < instr_cnt; i++)
        begin
            k = key[i];
            j = i;
            while (j > 0 && key[j-1] > k)
            begin
                key[j] = key[j-1];
                j--;
            end
            key[j] = k;
        end
        for (int i = 0; i < instr_cnt; i++)
        begin
            s.idx  = key[i][5:0];
            s.lvl  = key[i][20:14];
            s.op   = key[i][13:6];
            s.ovf  = dropped;
            s.last = (i == instr_cnt - 1);
            schedule_q = {schedule_q, s};
        end
    endtask

    // level bookkeeping for one accepted argument
    task automatic track_level(input arg_t a);
        int unsigned lvl;
        if (a.rd && level_of_addr[a.addr] > max_read_level)
            max_read_level = 32'(level_of_addr[a.addr]);
        if (a.wr)
        begin
            if (write_cnt < WRITE_CAP)
            begin
                write_addr[write_cnt] = a.addr;
                write_cnt++;
            end
            else
                dropped = 1'b1;
        end
        if (a.la || a.li)
        begin
            lvl = max_read_level + 1;
            if (lvl > 127)
                lvl = 127;
            if (instr_cnt < INSTR_CAP)
            begin
                instr_level[instr_cnt] = lvl[LEVEL_W-1:0];
                instr_op[instr_cnt] = a.op;
                instr_cnt++;
                for (int i = 0; i < write_cnt; i++)
                    level_of_addr[write_addr[i]] = lvl[LEVEL_W-1:0];
            end
            else
                dropped = 1'b1;
            write_cnt = 0;
            max_read_level = 0;
        end
        if (a.li)
        begin
            queue_schedule();
            clear_model();
        end
    endtask

    // one transfer on the input channel, called right after a rising edge
    task automatic send_arg(input arg_t a);
        while ($urandom_range(99, 0) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.arg_address <= a.addr;
        in_ch.arg_reads   <= a.rd;
        in_ch.arg_writes  <= a.wr;
        in_ch.op_kind     <= a.op;
        in_ch.last_arg    <= a.la;
        in_ch.last_instr  <= a.li;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_level(a);
        items_sent++;
    endtask

    task automatic send(input logic [ADDR_IN_W-1:0] addr, input logic rd, input logic wr,
                        input logic [OP_IN_W-1:0] op, input logic la, input logic li);
        arg_t a;
        a = '{addr: addr, rd: rd, wr: wr, op: op, la: la, li: li};
        send_arg(a);
    endtask

    // waits until the whole schedule has been drained
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (schedule_q.size() != 0)
            @(posedge clk);
    endtask

    // random program, addresses mostly from a small pool so dependencies chain
    task automatic send_program(input int n_instr, input int max_args);
        int nargs;
        logic [OP_IN_W-1:0] op;
        logic [ADDR_IN_W-1:0] addr;
        logic fin;
        for (int i = 0; i < n_instr; i++)
        begin
            op = OP_IN_W'($urandom_range(255, 0));
            nargs = $urandom_range(max_args, 0);
            if (nargs == 0)
                send(ADDR_IN_W'($urandom_range(1023, 0)), 1'b0, 1'b0, op, 1'b1,
                     i == n_instr - 1);
            for (int j = 0; j < nargs; j++)
            begin
                fin = (j == nargs - 1);
                if ($urandom_range(9, 0) == 0)
                    addr = ADDR_IN_W'($urandom_range(1023, 0));
                else
                    addr = ADDR_IN_W'($urandom_range(15, 0));
                // mixed op kinds now and then
                if ($urandom_range(7, 0) == 0)
                    op = OP_IN_W'($urandom_range(255, 0));
                if (fin && i == n_instr - 1)
                    send(addr, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), op,
                         1'($urandom_range(1, 0)), 1'b1);
                else
                    send(addr, $urandom_range(3, 0) != 0, $urandom_range(2, 0) == 0, op,
                         fin, 1'b0);
            end
        end
    endtask

    task automatic test_field_extremes();
        send(10'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
        send(10'h3ff, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0);
        send(10'h3ff, 1'b1, 1'b0, 8'h55, 1'b0, 1'b0);
        send(10'h2aa, 1'b1, 1'b1, 8'haa, 1'b1, 1'b0);
        send(10'h155, 1'b1, 1'b1, 8'h0f, 1'b1, 1'b0);
        send(10'h2aa, 1'b1, 1'b0, 8'h01, 1'b1, 1'b1);
        wait_drained();
    endtask

    // own writes hidden from own reads, op taken from closing item,
    // and last_instr closing an open instruction
    task automatic test_dependencies();
        send(10'd7, 1'b1, 1'b1, 8'd3, 1'b1, 1'b0);
        send(10'd7, 1'b1, 1'b1, 8'd9, 1'b0, 1'b0);
        send(10'd8, 1'b0, 1'b1, 8'd4, 1'b1, 1'b0);
        send(10'd8, 1'b1, 1'b0, 8'd200, 1'b0, 1'b0);
        send(10'd0, 1'b0, 1'b0, 8'd200, 1'b1, 1'b0);
        send(10'd3, 1'b1, 1'b0, 8'd4, 1'b0, 1'b1);
        wait_drained();
        send(10'd5, 1'b0, 1'b0, 8'd77, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_write_overflow();
        for (int i = 0; i < WRITE_CAP + 2; i++)
            send(ADDR_IN_W'(i), 1'b0, 1'b1, 8'd6, i == WRITE_CAP + 1, 1'b0);
        send(10'd9, 1'b1, 1'b0, 8'd6, 1'b1, 1'b0);
        send(10'd0, 1'b1, 1'b0, 8'd6, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_instr_overflow();
        send_program(INSTR_CAP + 3, 1);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(19, 0) == 0)
                send_program($urandom_range(20, 1), 12);
            else
                send_program($urandom_range(12, 1), 4);
            // hold off until the schedule is out now and then
            if ($urandom_range(3, 0) == 0)
                wait_drained();
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99, 0) >= snk_idle);

    // result check
    always @(posedge clk)
    begin
        sched_t exp_s;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (schedule_q.size() == 0)
            begin
                $error("unexpected result: instr_index %0d", out_ch.instr_index);
                errors++;
            end
            else
            begin
                exp_s = schedule_q.pop_front();
                if (out_ch.instr_index !== exp_s.idx)
                begin
                    $error("instr_index: expected %0d, got %0d", exp_s.idx, out_ch.instr_index);
                    errors++;
                end
                if (out_ch.sched_level !== exp_s.lvl)
                begin
                    $error("sched_level: expected %0d, got %0d", exp_s.lvl, out_ch.sched_level);
                    errors++;
                end
                if (out_ch.out_op_kind !== exp_s.op)
                begin
                    $error("out_op_kind: expected %0d, got %0d", exp_s.op, out_ch.out_op_kind);
                    errors++;
                end
                if (out_ch.overflow !== exp_s.ovf)
                begin
                    $error("overflow: expected %0d, got %0d", exp_s.ovf, out_ch.overflow);
                    errors++;
                end
                if (out_ch.last !== exp_s.last)
                begin
                    $error("last: expected %0d, got %0d", exp_s.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        items_sent = 0;
        src_idle = 12;
        snk_idle = 79;
        clear_model();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.arg_address = '0;
        in_ch.arg_reads = 1'b0;
        in_ch.arg_writes = 1'b0;
        in_ch.op_kind = '0;
        in_ch.last_arg = 1'b0;
        in_ch.last_instr = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_dependencies();
        test_write_overflow();
        test_instr_overflow();
        test_random(90);
        src_idle = 79;
        snk_idle = 12;
        test_random(90);
        src_idle = 0;
        snk_idle = 0;
        test_random(90);

        // drain and settle
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
